// ===== sv/gdsb_pkg.sv =====
// Shared types, codes and constants for the gate driver bring-up sequencer.
// No dependencies; every other file imports this package.
package gdsb_pkg;

    localparam int NUM_SETTING_WORDS_DEF = 5;
    localparam int NUM_STATUS_WORDS_DEF  = 2;
    localparam int CFG_SETTING_REGS      = 5;
    localparam int MAX_SETTING_WORDS     = 8;
    localparam int MAX_STATUS_WORDS      = 4;
    localparam int DATA_W                = 11;
    localparam int WAIT_W                = 8;
    localparam int STEP_W                = 8;
    localparam int ADDR_W                = 4;
    localparam int FRAME_W               = 16;
    localparam int CFG_IDX_W             = 3;
    localparam int QUEUE_DEPTH           = 4;

    typedef logic [DATA_W-1:0] t_data;

    localparam t_data SETTING_RESET [CFG_SETTING_REGS] =
        '{11'd512, 11'd802, 11'd1570, 11'd804, 11'd643};
    localparam logic [WAIT_W-1:0] WAIT_RESET = 8'd250;
    localparam logic [ADDR_W-1:0] SETTING_BASE_ADDR = 4'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WAKE_WAIT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SLEEP_WAIT = 3'd6;

    // Input opcodes
    localparam logic [1:0] OP_PREPARE = 2'd0;
    localparam logic [1:0] OP_TICK    = 2'd1;
    localparam logic [1:0] OP_REPLY   = 2'd2;

    // Prepare targets
    localparam logic [1:0] TGT_ENABLE  = 2'd0;
    localparam logic [1:0] TGT_DISABLE = 2'd1;
    localparam logic [1:0] TGT_STATUS  = 2'd2;

    // Phase codes as shown on the result
    localparam logic [2:0] PH_INIT       = 3'd0;
    localparam logic [2:0] PH_WAIT_SLEEP = 3'd1;
    localparam logic [2:0] PH_WAIT_WAKE  = 3'd2;
    localparam logic [2:0] PH_WRITE      = 3'd3;
    localparam logic [2:0] PH_READBACK   = 3'd4;
    localparam logic [2:0] PH_STATUS     = 3'd5;
    localparam logic [2:0] PH_DONE       = 3'd6;
    localparam logic [2:0] PH_FAILED     = 3'd7;

    typedef enum logic [1:0] {
        KIND_PREPARE,
        KIND_TICK,
        KIND_REPLY,
        KIND_IGNORE
    } t_kind;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [1:0]  target_operation;
        logic [15:0] reply_word;
    } t_item;

    typedef struct packed {
        logic        frame_valid;
        logic [15:0] frame_word;
        logic        gate_enable;
        logic [2:0]  phase;
        logic        unreachable;
        logic [10:0] fault_status_one;
        logic [10:0] fault_status_two;
    } t_result;

    typedef struct packed {
        t_kind      kind;
        logic [1:0] target;
        t_data      reply;
    } t_cmd;

    function automatic logic [FRAME_W-1:0] make_frame(input logic rd,
                                                      input logic [ADDR_W-1:0] addr,
                                                      input t_data data);
        return {rd, addr, data};
    endfunction

endpackage

// ===== sv/gdsb_front.sv =====
// Front end: classifies incoming beats and holds them in a short command queue.
// Depends on gdsb_pkg.
module gdsb_front
    import gdsb_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    output logic  o_cmd_valid,
    output t_cmd  o_cmd,
    input  logic  i_cmd_take
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    t_cmd             w_cmd;
    logic             w_push_acc;
    logic             w_take;

    // Classify the beat and keep only the low data bits of the reply
    always_comb begin
        w_cmd.target = i_item.target_operation;
        w_cmd.reply  = i_item.reply_word[DATA_W-1:0];
        unique case (i_item.opcode)
            OP_PREPARE: w_cmd.kind = KIND_PREPARE;
            OP_TICK:    w_cmd.kind = KIND_TICK;
            OP_REPLY:   w_cmd.kind = KIND_REPLY;
            default:    w_cmd.kind = KIND_IGNORE;
        endcase
    end

    assign o_full      = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_mem[r_rd_ptr];
    assign w_push_acc  = i_push && !o_full;
    assign w_take      = i_cmd_take && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (w_push_acc) begin
            r_mem[r_wr_ptr] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push_acc) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_take) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push_acc && !w_take) begin
                r_count <= r_count + 1'b1;
            end else if (!w_push_acc && w_take) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== sv/gdsb_back.sv =====
// Back end: configuration registers, bring-up sequencer and result register.
// Depends on gdsb_pkg.
module gdsb_back
    import gdsb_pkg::*;
#(
    parameter int NUM_SETTING_WORDS = NUM_SETTING_WORDS_DEF,
    parameter int NUM_STATUS_WORDS  = NUM_STATUS_WORDS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  t_data                i_cfg_data,
    input  logic                 i_cmd_valid,
    input  t_cmd                 i_cmd,
    output logic                 o_cmd_take,
    output logic                 o_empty,
    input  logic                 i_pop,
    output t_result              o_res
);

    typedef enum logic [2:0] {
        S_INIT        = PH_INIT,
        S_WAIT_SLEEP  = PH_WAIT_SLEEP,
        S_WAIT_WAKE   = PH_WAIT_WAKE,
        S_WRITE       = PH_WRITE,
        S_READBACK    = PH_READBACK,
        S_READ_STATUS = PH_STATUS,
        S_DONE        = PH_DONE,
        S_FAILED      = PH_FAILED
    } t_phase;

    localparam logic [STEP_W-1:0] N_SET  = STEP_W'(NUM_SETTING_WORDS);
    localparam logic [STEP_W-1:0] N_STAT = STEP_W'(NUM_STATUS_WORDS);

    t_data             r_setting [CFG_SETTING_REGS];
    logic [WAIT_W-1:0] r_wake_wait;
    logic [WAIT_W-1:0] r_sleep_wait;

    t_phase            r_phase,   n_phase;
    logic [1:0]        r_target,  n_target;
    logic [STEP_W-1:0] r_step,    n_step;
    logic              r_await,   n_await;
    logic              r_mism,    n_mism;
    logic              r_enable,  n_enable;
    logic              r_unreach, n_unreach;
    t_data             r_status [MAX_STATUS_WORDS];
    t_data             n_status [MAX_STATUS_WORDS];
    logic              r_out_valid;
    t_result           r_res,     n_res;

    t_data             w_set_tab [MAX_SETTING_WORDS];
    t_data             w_set_cur;
    logic [STEP_W-1:0] w_k;
    logic              w_take;
    logic              w_fv;
    logic [FRAME_W-1:0] w_fw;

    // Words beyond the configured five read as zero
    always_comb begin
        for (int i = 0; i < MAX_SETTING_WORDS; i++) begin
            w_set_tab[i] = '0;
        end
        for (int i = 0; i < CFG_SETTING_REGS; i++) begin
            w_set_tab[i] = r_setting[i];
        end
    end

    assign w_set_cur  = w_set_tab[r_step[$clog2(MAX_SETTING_WORDS)-1:0]];
    assign w_k        = r_step - 1'b1;
    assign w_take     = i_cmd_valid && (!r_out_valid || i_pop);
    assign o_cmd_take = w_take;
    assign o_empty    = !r_out_valid;
    assign o_res      = r_res;

    always_comb begin
        n_phase   = r_phase;
        n_target  = r_target;
        n_step    = r_step;
        n_await   = r_await;
        n_mism    = r_mism;
        n_enable  = r_enable;
        n_unreach = r_unreach;
        n_status  = r_status;
        w_fv      = 1'b0;
        w_fw      = '0;

        unique case (i_cmd.kind)
            KIND_PREPARE: begin
                n_target = i_cmd.target;
                n_phase  = S_INIT;
                n_await  = 1'b0;
            end
            KIND_TICK: begin
                unique case (r_phase)
                    S_INIT: begin
                        case (r_target)
                            TGT_ENABLE: begin
                                n_enable = 1'b1;
                                n_phase  = S_WAIT_WAKE;
                                n_step   = '0;
                            end
                            TGT_DISABLE: begin
                                n_enable = 1'b0;
                                n_phase  = S_WAIT_SLEEP;
                                n_step   = '0;
                            end
                            TGT_STATUS: begin
                                n_phase = S_READ_STATUS;
                                n_step  = '0;
                            end
                            default: ;
                        endcase
                    end
                    S_WAIT_SLEEP: begin
                        if (r_step < r_sleep_wait) begin
                            n_step = r_step + 1'b1;
                        end else begin
                            n_phase = S_DONE;
                            n_step  = '0;
                        end
                    end
                    S_WAIT_WAKE: begin
                        if (r_step < r_wake_wait) begin
                            n_step = r_step + 1'b1;
                        end else begin
                            n_phase = S_WRITE;
                            n_step  = '0;
                        end
                    end
                    S_WRITE: begin
                        if (r_step < N_SET) begin
                            w_fv   = 1'b1;
                            w_fw   = make_frame(1'b0,
                                                SETTING_BASE_ADDR + r_step[ADDR_W-1:0],
                                                w_set_cur);
                            n_step = r_step + 1'b1;
                        end else begin
                            n_phase = S_READBACK;
                            n_step  = '0;
                            n_mism  = 1'b0;
                            n_await = 1'b0;
                        end
                    end
                    S_READBACK: begin
                        // A reply still pending here never arrived: count a mismatch
                        n_mism  = r_mism || r_await;
                        n_await = 1'b0;
                        if (r_step < N_SET) begin
                            w_fv     = 1'b1;
                            w_fw     = make_frame(1'b1,
                                                  SETTING_BASE_ADDR + r_step[ADDR_W-1:0],
                                                  '0);
                            n_await  = 1'b1;
                            n_step   = r_step + 1'b1;
                        end else if (!n_mism) begin
                            n_unreach = 1'b0;
                            n_phase   = S_READ_STATUS;
                            n_step    = '0;
                        end else begin
                            n_enable  = 1'b0;
                            n_unreach = 1'b1;
                            n_phase   = S_FAILED;
                        end
                    end
                    S_READ_STATUS: begin
                        n_await = 1'b0;
                        if (r_step < N_STAT) begin
                            w_fv    = 1'b1;
                            w_fw    = make_frame(1'b1, r_step[ADDR_W-1:0], '0);
                            n_await = 1'b1;
                            n_step  = r_step + 1'b1;
                        end else begin
                            n_phase = S_DONE;
                            n_step  = '0;
                        end
                    end
                    S_DONE, S_FAILED: ;
                endcase
            end
            KIND_REPLY: begin
                if (r_await && (r_step != '0)) begin
                    if (r_phase == S_READBACK) begin
                        // Compare against the setting word as it stands now
                        if (i_cmd.reply != w_set_tab[w_k[$clog2(MAX_SETTING_WORDS)-1:0]]) begin
                            n_mism = 1'b1;
                        end
                    end else if (r_phase == S_READ_STATUS && w_k < N_STAT) begin
                        n_status[w_k[1:0]] = i_cmd.reply;
                    end
                end
                n_await = 1'b0;
            end
            KIND_IGNORE: ;
        endcase

        n_res.frame_valid      = w_fv;
        n_res.frame_word       = w_fw;
        n_res.gate_enable      = n_enable;
        n_res.phase            = n_phase;
        n_res.unreachable      = n_unreach;
        n_res.fault_status_one = n_status[0];
        n_res.fault_status_two = (NUM_STATUS_WORDS > 1) ? n_status[1] : '0;
    end

    // Result payload: load on take, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CFG_SETTING_REGS; i++) begin
                r_setting[i] <= SETTING_RESET[i];
            end
            r_wake_wait  <= WAIT_RESET;
            r_sleep_wait <= WAIT_RESET;
            r_phase      <= S_DONE;
            r_target     <= '0;
            r_step       <= '0;
            r_await      <= 1'b0;
            r_mism       <= 1'b0;
            r_enable     <= 1'b0;
            r_unreach    <= 1'b0;
            for (int i = 0; i < MAX_STATUS_WORDS; i++) begin
                r_status[i] <= '0;
            end
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx < CFG_WAKE_WAIT) begin
                    r_setting[i_cfg_idx] <= i_cfg_data;
                end else if (i_cfg_idx == CFG_WAKE_WAIT) begin
                    r_wake_wait <= i_cfg_data[WAIT_W-1:0];
                end else if (i_cfg_idx == CFG_SLEEP_WAIT) begin
                    r_sleep_wait <= i_cfg_data[WAIT_W-1:0];
                end
            end
            if (w_take) begin
                r_phase     <= n_phase;
                r_target    <= n_target;
                r_step      <= n_step;
                r_await     <= n_await;
                r_mism      <= n_mism;
                r_enable    <= n_enable;
                r_unreach   <= n_unreach;
                r_status    <= n_status;
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== sv/gate_driver_spi_bringup_sequencer.sv =====
// Top level of the gate driver bring-up sequencer.
// Depends on gdsb_pkg, gdsb_front and gdsb_back.
//
// Usage:
//   Input channel (push/full): each beat is one item of t_item - a prepare
//   (choose enable, disable or status read), a PWM period tick, or an SPI
//   reply. A beat is taken on a clock edge with push high and full low.
//   Result channel (empty/pop): every input beat yields exactly one t_result
//   beat, in order, showing the frame to send (if any), gate enable, phase,
//   unreachable flag and the last fault status words.
//   Configuration: i_cfg_we/i_cfg_idx/i_cfg_data write the five setting words
//   (indexes 0..4) and the wake and sleep wait counts (5 and 6); index 7 is
//   dropped. Write only while the block is idle.
// Flow:
//   A beat enters a four-entry command queue in the front end; the back end
//   takes one command a cycle into its output register while that register is
//   empty or being popped, so each beat passes through the queue and then the
//   output register, and one beat per cycle is sustained while pop stays high.
// Reset: synchronous, active low; empties the command queue and the result register,
//   loads the default settings and leaves the sequencer in the done phase, gate disabled.
// Stalls: with pop low the result holds; the back end halts and the command
//   queue absorbs up to four further beats before full rises.
module gate_driver_spi_bringup_sequencer
    import gdsb_pkg::*;
#(
    parameter int NUM_SETTING_WORDS = NUM_SETTING_WORDS_DEF,
    parameter int NUM_STATUS_WORDS  = NUM_STATUS_WORDS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    input  t_item                i_item,
    output logic                 full,
    output logic                 empty,
    input  logic                 pop,
    output t_result              o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  t_data                i_cfg_data
);

    logic w_cmd_valid;
    t_cmd w_cmd;
    logic w_cmd_take;

    // Front end: classify and queue each beat
    gdsb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .o_full      (full),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_take  (w_cmd_take)
    );

    // Back end: advance the sequence and hold the result beat
    gdsb_back #(
        .NUM_SETTING_WORDS (NUM_SETTING_WORDS),
        .NUM_STATUS_WORDS  (NUM_STATUS_WORDS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_take  (w_cmd_take),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_res       (o_res)
    );

endmodule

// ===== sv/gdsb_checker.sv =====
// Port-level checks for the gate driver bring-up sequencer, bound to the top.
// Depends on gdsb_pkg and gate_driver_spi_bringup_sequencer.
module gdsb_checker
    import gdsb_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    empty,
    input logic    pop,
    input t_result o_res
);

    // A waiting result beat holds until popped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_res)))
        else $error("result beat changed while stalled");

    a_no_frame_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_res.frame_valid) |-> (o_res.frame_word == '0))
        else $error("frame word set without a frame");

    a_frame_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_res.frame_valid) |->
            (o_res.phase == PH_WRITE || o_res.phase == PH_READBACK ||
             o_res.phase == PH_STATUS))
        else $error("frame issued outside write, readback or status");

    a_failed_safe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_res.phase == PH_FAILED) |->
            (o_res.unreachable && !o_res.gate_enable))
        else $error("failed phase with gate enabled or flag clear");

endmodule

bind gate_driver_spi_bringup_sequencer gdsb_checker u_gdsb_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .empty   (empty),
    .pop     (pop),
    .o_res   (o_res)
);

// ===== verif/tb_gate_driver_spi_bringup_sequencer.sv =====
// Self-checking bench for the gate driver bring-up sequencer: directed and random beats,
// each report compared field by field against a cycle-free model of the sequencer.
// Depends on gdsb_pkg and gate_driver_spi_bringup_sequencer.
module tb_gate_driver_spi_bringup_sequencer;
    import gdsb_pkg::*;

    localparam int NUM_SW      = NUM_SETTING_WORDS_DEF;
    localparam int NUM_STW     = NUM_STATUS_WORDS_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_BEATS = 200;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            push = 1'b0;
    t_item           i_item = '0;
    logic            full;
    logic            empty;
    logic            pop = 1'b0;
    t_result         o_res;
    logic            i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    t_data           i_cfg_data = '0;

    gate_driver_spi_bringup_sequencer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .i_item     (i_item),
        .full       (full),
        .empty      (empty),
        .pop        (pop),
        .o_res      (o_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow of the programmed registers
    t_data       cfg_setting [MAX_SETTING_WORDS];
    logic [7:0]  cfg_wake;
    logic [7:0]  cfg_sleep;

    // Shadow of the sequencer state, updated as each beat is accepted
    logic [2:0]  seq_phase = PH_DONE;
    logic [1:0]  seq_target = TGT_ENABLE;
    logic [7:0]  seq_step = '0;
    logic        seq_await = 1'b0;
    logic        seq_mismatch = 1'b0;
    logic        seq_enable = 1'b0;
    logic        seq_unreach = 1'b0;
    t_data       seq_status [MAX_STATUS_WORDS] = '{default: '0};

    t_result     report_q [$];
    int          n_errors = 0;
    int          items_sent = 0;
    int          cycle_count = 0;
    int          pop_hold = 0;
    bit          idle_bursts = 1'b1;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Advance the sequencer shadow by one beat and return the report it should give.
    function automatic t_result predict_report(input t_item it);
        t_result     r;
        t_data       reply;
        logic [7:0]  k;
        logic [ADDR_W-1:0] addr;
        r = '0;
        reply = it.reply_word[DATA_W-1:0];
        k = seq_step - 8'd1;
        case (it.opcode)
            OP_PREPARE: begin
                // Restart from init; any read still in flight is forgotten
                seq_target = it.target_operation;
                seq_phase  = PH_INIT;
                seq_await  = 1'b0;
            end
            OP_TICK: begin
                case (seq_phase)
                    PH_INIT: begin
                        if (seq_target == TGT_ENABLE) begin
                            seq_enable = 1'b1;
                            seq_phase  = PH_WAIT_WAKE;
                            seq_step   = '0;
                        end else if (seq_target == TGT_DISABLE) begin
                            seq_enable = 1'b0;
                            seq_phase  = PH_WAIT_SLEEP;
                            seq_step   = '0;
                        end else if (seq_target == TGT_STATUS) begin
                            seq_phase = PH_STATUS;
                            seq_step  = '0;
                        end
                        // an unknown target holds in init
                    end
                    PH_WAIT_SLEEP: begin
                        if (seq_step < cfg_sleep) begin
                            seq_step++;
                        end else begin
                            seq_phase = PH_DONE;
                            seq_step  = '0;
                        end
                    end
                    PH_WAIT_WAKE: begin
                        if (seq_step < cfg_wake) begin
                            seq_step++;
                        end else begin
                            seq_phase = PH_WRITE;
                            seq_step  = '0;
                        end
                    end
                    PH_WRITE: begin
                        if (seq_step < NUM_SW) begin
                            addr = SETTING_BASE_ADDR + seq_step[ADDR_W-1:0];
                            r.frame_valid = 1'b1;
                            r.frame_word  = {1'b0, addr, cfg_setting[seq_step[2:0]]};
                            seq_step++;
                        end else begin
                            seq_phase    = PH_READBACK;
                            seq_step     = '0;
                            seq_mismatch = 1'b0;
                            seq_await    = 1'b0;
                        end
                    end
                    PH_READBACK: begin
                        // A readback reply that never came counts as a mismatch
                        if (seq_await) begin
                            seq_mismatch = 1'b1;
                            seq_await    = 1'b0;
                        end
                        if (seq_step < NUM_SW) begin
                            addr = SETTING_BASE_ADDR + seq_step[ADDR_W-1:0];
                            r.frame_valid = 1'b1;
                            r.frame_word  = {1'b1, addr, {DATA_W{1'b0}}};
                            seq_await = 1'b1;
                            seq_step++;
                        end else if (!seq_mismatch) begin
                            seq_unreach = 1'b0;
                            seq_phase   = PH_STATUS;
                            seq_step    = '0;
                        end else begin
                            seq_enable  = 1'b0;
                            seq_unreach = 1'b1;
                            seq_phase   = PH_FAILED;
                        end
                    end
                    PH_STATUS: begin
                        seq_await = 1'b0;
                        if (seq_step < NUM_STW) begin
                            r.frame_valid = 1'b1;
                            r.frame_word  = {1'b1, seq_step[ADDR_W-1:0], {DATA_W{1'b0}}};
                            seq_await = 1'b1;
                            seq_step++;
                        end else begin
                            seq_phase = PH_DONE;
                            seq_step  = '0;
                        end
                    end
                    default: ;
                endcase
            end
            OP_REPLY: begin
                // Only a pending read takes the reply; anything else is stray
                if (seq_await && seq_step > 0) begin
                    if (seq_phase == PH_READBACK) begin
                        if (reply != cfg_setting[k[2:0]]) seq_mismatch = 1'b1;
                    end else if (seq_phase == PH_STATUS) begin
                        seq_status[k[1:0]] = reply;
                    end
                end
                seq_await = 1'b0;
            end
            default: ;
        endcase
        r.gate_enable      = seq_enable;
        r.phase            = seq_phase;
        r.unreachable      = seq_unreach;
        r.fault_status_one = seq_status[0];
        r.fault_status_two = (NUM_STW > 1) ? seq_status[1] : '0;
        return r;
    endfunction

    function automatic t_item make_item(input logic [1:0] op, input logic [1:0] tgt,
                                        input logic [15:0] reply);
        t_item it;
        it.opcode           = op;
        it.target_operation = tgt;
        it.reply_word       = reply;
        return it;
    endfunction

    // Offer one beat, with an occasional gap first, and hold it until taken.
    // Push stays high on return so back-to-back beats need no second assignment.
    task automatic send_item(input t_item it);
        if (idle_bursts && $urandom_range(0, 3) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        report_q.push_back(predict_report(it));
        items_sent++;
    endtask

    // Drop push, let every outstanding report drain, then allow the pipeline to settle.
    task automatic wait_idle();
        push <= 1'b0;
        while (report_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Program every register, one write per cycle, only once the block is quiet.
    task automatic write_config(input t_data words [CFG_SETTING_REGS],
                                input logic [7:0] wake, input logic [7:0] sleep_w);
        wait_idle();
        for (int i = 0; i < CFG_SETTING_REGS; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_IDX_W'(i);
            i_cfg_data <= words[i];
            cfg_setting[i] = words[i];
            @(posedge i_clk);
        end
        // upper data bits are junk for the wait registers and must be dropped
        i_cfg_idx  <= CFG_WAKE_WAIT;
        i_cfg_data <= {3'($urandom), wake};
        cfg_wake = wake;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_SLEEP_WAIT;
        i_cfg_data <= {3'($urandom), sleep_w};
        cfg_sleep = sleep_w;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Walk one operation to its end: tick, and answer each read the way a
    // healthy part would, with the odd wrong, lost or stray reply mixed in.
    // Restarts land outside the wait phases so long waits still finish.
    task automatic run_bringup(input logic [1:0] tgt);
        int    guard;
        int    pick;
        t_data word;
        send_item(make_item(OP_PREPARE, tgt, 16'($urandom)));
        guard = 0;
        while (seq_phase != PH_DONE && seq_phase != PH_FAILED && guard < 600) begin
            guard++;
            send_item(make_item(OP_TICK, 2'($urandom), 16'($urandom)));
            pick = $urandom_range(0, 99);
            if (seq_await) begin
                word = (seq_phase == PH_READBACK) ? cfg_setting[3'(seq_step - 8'd1)]
                                                  : t_data'($urandom);
                if (pick < 8) word = word ^ t_data'($urandom_range(1, 2047));
                if (pick < 88)
                    send_item(make_item(OP_REPLY, 2'($urandom), {5'($urandom), word}));
            end else if (pick < 4) begin
                send_item(make_item(OP_REPLY, 2'($urandom), 16'($urandom)));
            end else if (pick < 6 && seq_phase != PH_WAIT_WAKE &&
                         seq_phase != PH_WAIT_SLEEP) begin
                send_item(make_item(OP_PREPARE, tgt, 16'($urandom)));
            end
        end
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 6))
            send_item(make_item(2'($urandom), 2'($urandom), 16'($urandom)));
    endtask

    // Unknown opcode, unknown target held in init, stray reply; reset settings apply
    task automatic test_odd_items();
        send_item(make_item(2'b11, 2'b11, 16'hFFFF));
        send_item(make_item(OP_PREPARE, 2'b11, 16'h0000));
        send_item(make_item(OP_TICK, 2'b11, 16'hFFFF));
        send_item(make_item(OP_REPLY, 2'b00, 16'hFFFF));
    endtask

    // Status read with a full-scale reply, a reply lost to a prepare, and a stray one
    task automatic test_status_read();
        send_item(make_item(OP_PREPARE, TGT_STATUS, 16'h0000));
        send_item(make_item(OP_TICK, 2'b00, 16'h0000));
        send_item(make_item(OP_TICK, 2'b00, 16'h0000));
        send_item(make_item(OP_REPLY, 2'b00, 16'hFFFF));
        send_item(make_item(OP_TICK, 2'b00, 16'h0000));
        send_item(make_item(OP_PREPARE, TGT_STATUS, 16'h0000));
        send_item(make_item(OP_REPLY, 2'b00, 16'h5555));
    endtask

    // Enable with zero wake wait: writes, then a readback with one missing reply,
    // one wrong and three good ones, which must end in the failed phase.
    task automatic test_enable_readback();
        t_data words [CFG_SETTING_REGS];
        words = '{11'd0, 11'd2047, 11'd1365, 11'd682, 11'd1};
        write_config(words, 8'd0, 8'd0);
        send_item(make_item(OP_PREPARE, TGT_ENABLE, 16'h0000));
        repeat (8) send_item(make_item(OP_TICK, 2'b00, 16'h0000));
        send_item(make_item(OP_TICK, 2'b00, 16'h0000));
        send_item(make_item(OP_REPLY, 2'b00, {5'h1F, cfg_setting[0]}));
        send_item(make_item(OP_TICK, 2'b00, 16'h0000));
        send_item(make_item(OP_TICK, 2'b00, 16'h0000));
        send_item(make_item(OP_REPLY, 2'b00, {5'h00, ~cfg_setting[2]}));
        send_item(make_item(OP_TICK, 2'b00, 16'h0000));
        send_item(make_item(OP_REPLY, 2'b00, {5'h00, cfg_setting[3]}));
        send_item(make_item(OP_TICK, 2'b00, 16'h0000));
        send_item(make_item(OP_REPLY, 2'b00, {5'h00, cfg_setting[4]}));
        send_item(make_item(OP_TICK, 2'b00, 16'h0000));
    endtask

    // Longest wake wait through a full enable, full-scale setting words
    task automatic test_long_waits();
        t_data words [CFG_SETTING_REGS];
        words = '{default: 11'd2047};
        write_config(words, 8'd255, 8'd255);
        run_bringup(TGT_ENABLE);
    endtask

    // Segments of random settings, each followed by a handful of operations
    // and noise; the closing segments run without any idling.
    task automatic test_random_traffic();
        t_data words [CFG_SETTING_REGS];
        int    start;
        int    r;
        start = items_sent;
        while (items_sent - start < RANDOM_BEATS) begin
            foreach (words[i]) begin
                r = $urandom_range(0, 3);
                words[i] = (r == 0) ? 11'd0 : (r == 1) ? 11'd2047 : t_data'($urandom);
            end
            write_config(words,
                         ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 6)),
                         ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 6)));
            idle_bursts = (items_sent - start < RANDOM_BEATS - 100) &&
                          ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(3, 8)) begin
                r = $urandom_range(0, 9);
                if (r < 4)
                    run_bringup(TGT_ENABLE);
                else if (r < 6)
                    run_bringup(TGT_DISABLE);
                else if (r < 8)
                    run_bringup(TGT_STATUS);
                else
                    send_noise();
            end
        end
        idle_bursts = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            n_errors++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        end
    endtask

    // Result side: stall in bursts while idling is on, otherwise pop every cycle
    always @(posedge i_clk) begin
        if (pop_hold != 0) begin
            pop_hold <= pop_hold - 1;
            pop      <= 1'b0;
        end else if (idle_bursts && $urandom_range(0, 4) == 0) begin
            pop_hold <= $urandom_range(0, 5);
            pop      <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    // Compare each popped report with the oldest prediction
    always @(posedge i_clk) begin : check_reports
        t_result want;
        if (i_rst_n && pop && !empty) begin
            if (report_q.size() == 0) begin
                n_errors++;
                $display("%0t: report with none expected, expected none actual %h",
                         $time, o_res);
            end else begin
                want = report_q.pop_front();
                check_field("frame_valid", 16'(want.frame_valid), 16'(o_res.frame_valid));
                check_field("frame_word", want.frame_word, o_res.frame_word);
                check_field("gate_enable", 16'(want.gate_enable), 16'(o_res.gate_enable));
                check_field("phase", 16'(want.phase), 16'(o_res.phase));
                check_field("unreachable", 16'(want.unreachable), 16'(o_res.unreachable));
                check_field("fault_status_one", 16'(want.fault_status_one),
                            16'(o_res.fault_status_one));
                check_field("fault_status_two", 16'(want.fault_status_two),
                            16'(o_res.fault_status_two));
            end
        end
    end

    // Watchdog: a hung handshake ends the run here
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_gate_driver_spi_bringup_sequencer: FAIL");
            $finish;
        end
    end

    initial begin
        // Load the reset register values into the shadow
        foreach (cfg_setting[i])
            cfg_setting[i] = (i < CFG_SETTING_REGS) ? SETTING_RESET[i] : '0;
        cfg_wake  = WAIT_RESET;
        cfg_sleep = WAIT_RESET;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_odd_items();
        test_status_read();
        test_enable_readback();
        test_long_waits();
        test_random_traffic();
        wait_idle();

        if (report_q.size() != 0) begin
            n_errors++;
            $display("%0t: reports left over, expected %0d more actual 0",
                     $time, report_q.size());
        end
        if (n_errors == 0) begin
            $display("tb_gate_driver_spi_bringup_sequencer: PASS");
        end else begin
            $display("tb_gate_driver_spi_bringup_sequencer: FAIL");
        end
        $finish;
    end

endmodule
